### rtl/rec_pkg.sv
// ----------------------------------------------------------------------------
// rec_pkg
// Shared types and constants for the range encoder with carry propagation.
// ----------------------------------------------------------------------------
package rec_pkg;

    localparam logic [31:0] C_RANGE_START = 32'h8000_0000;
    localparam logic [31:0] C_RANGE_FLOOR = 32'h0080_0000;
    localparam logic [31:0] C_LOW_ZONE    = 32'h7F80_0000;
    localparam logic [31:0] C_LOW_KEEP    = 32'h007F_FFFF;
    localparam logic [31:0] C_TRAILER     = 32'd5;
    localparam logic [1:0]  C_MAX_SHIFTS  = 2'd3;
    localparam logic [4:0]  C_PREC_RESET  = 5'd12;
    localparam logic [7:0]  C_FILL_ONES   = 8'hFF;
    localparam logic [7:0]  C_FILL_ZEROS  = 8'h00;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [1:0] {
        CFG_FIRST_BYTE = 2'd0,
        CFG_START_POS  = 2'd1,
        CFG_PRECISION  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EM_HELD = 3'd0,
        EM_RUN  = 3'd1,
        EM_RND  = 3'd2,
        EM_POS2 = 3'd3,
        EM_POS1 = 3'd4,
        EM_POS0 = 3'd5
    } t_emit_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REN_TEST,
        ST_REN_HELD,
        ST_REN_RUN,
        ST_ENC_MUL,
        ST_ENC_UPD,
        ST_FIN_POS,
        ST_FIN_RND,
        ST_FIN_HELD,
        ST_FIN_RUN,
        ST_FIN_B0,
        ST_FIN_B1,
        ST_FIN_B2,
        ST_FIN_B3,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic      idle;
        logic      load;
        logic      shift;
        logic      pend_inc;
        logic      pend_clr;
        logic      emit;
        t_emit_sel emit_sel;
        logic      fin;
        logic      mul_cum;
        logic      enc_upd;
        logic      pos_add;
        logic      rnd_calc;
        logic      restore;
        logic      flush;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_fin;
        logic range_low;
        logic lo_zone;
        logic lo_top;
        logic pend_nz;
        logic emit_ok;
        logic flush_ok;
        logic stg_valid;
    } t_dp_sts;

endpackage

### rtl/rec_dp.sv
// ----------------------------------------------------------------------------
// rec_dp
// Datapath: coder state, configuration registers, multiplier, result staging
// register and output register.
// ----------------------------------------------------------------------------
module rec_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rec_pkg::t_dp_cmd i_cmd,
    output rec_pkg::t_dp_sts o_sts,
    input  logic             i_command,
    input  logic [16:0]      i_sym_freq,
    input  logic [15:0]      i_cum_freq,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic [31:0]      o_repeat_count,
    output logic             o_last
);

    logic [7:0]  r_cfg_first;
    logic [31:0] r_cfg_start;
    logic [4:0]  r_cfg_prec;
    logic [31:0] r_low;
    logic [31:0] r_range;
    logic [7:0]  r_held;
    logic [31:0] r_pend;
    logic [31:0] r_pos;
    logic        r_started;
    logic        r_cmd;
    logic [16:0] r_freq;
    logic [15:0] r_cum;
    logic [31:0] r_prod;
    logic [9:0]  r_rnd;
    logic        r_stg_valid;
    logic [7:0]  r_stg_byte;
    logic [31:0] r_stg_count;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [31:0] r_out_count;
    logic        r_out_last;

    logic [31:0] w_step;
    logic [16:0] w_mul_a;
    logic [48:0] w_mul_full;
    logic [31:0] w_prod;
    logic [17:0] w_sum;
    logic        w_use_sub;
    logic        w_round_up;
    logic [9:0]  w_rnd_next;
    logic        w_carry;
    logic [7:0]  w_held_inc;
    logic [31:0] w_pend_inc;
    logic [7:0]  w_em_byte;
    logic [31:0] w_em_count;
    logic        w_out_free;
    logic        w_cfg_we;
    logic        w_push;
    logic        n_out_valid;

    assign w_step     = r_range >> r_cfg_prec;
    assign w_mul_a    = i_cmd.mul_cum ? {1'b0, r_cum} : r_freq;
    assign w_mul_full = {32'd0, w_mul_a} * {17'd0, w_step};
    assign w_prod     = w_mul_full[31:0];
    assign w_sum      = {1'b0, r_freq} + {2'b00, r_cum};
    assign w_use_sub  = (w_sum >> r_cfg_prec) != 18'd0;
    assign w_round_up = (r_low & rec_pkg::C_LOW_KEEP) >= ((r_pos >> 1) & rec_pkg::C_LOW_KEEP);
    assign w_rnd_next = {1'b0, r_low[31:23]} + {9'd0, w_round_up};
    assign w_carry    = i_cmd.fin ? (r_rnd[9:8] != 2'b00) : r_low[31];
    assign w_held_inc = r_held + 8'd1;
    assign w_pend_inc = (r_pend == 32'hFFFF_FFFF) ? r_pend : r_pend + 32'd1;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_we   = i_cfg_valid && i_cmd.idle;
    assign w_push     = (i_cmd.emit && r_stg_valid) || i_cmd.flush;

    always_comb begin
        w_em_byte  = r_held;
        w_em_count = 32'd1;
        unique case (i_cmd.emit_sel)
            rec_pkg::EM_HELD: begin
                w_em_byte = w_carry ? w_held_inc : r_held;
            end
            rec_pkg::EM_RUN: begin
                w_em_byte  = w_carry ? rec_pkg::C_FILL_ZEROS : rec_pkg::C_FILL_ONES;
                w_em_count = r_pend;
            end
            rec_pkg::EM_RND:  w_em_byte = r_rnd[7:0];
            rec_pkg::EM_POS2: w_em_byte = r_pos[23:16];
            rec_pkg::EM_POS1: w_em_byte = r_pos[15:8];
            rec_pkg::EM_POS0: w_em_byte = r_pos[7:0];
            default: begin
                w_em_byte  = r_held;
                w_em_count = 32'd1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_push) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_first <= 8'd0;
            r_cfg_start <= 32'd0;
            r_cfg_prec  <= rec_pkg::C_PREC_RESET;
            r_low       <= 32'd0;
            r_range     <= rec_pkg::C_RANGE_START;
            r_held      <= 8'd0;
            r_pend      <= 32'd0;
            r_pos       <= 32'd0;
            r_started   <= 1'b0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                unique case (rec_pkg::t_cfg_idx'(i_cfg_index))
                    rec_pkg::CFG_FIRST_BYTE: begin
                        r_cfg_first <= i_cfg_data[7:0];
                        if (!r_started) begin
                            r_held <= i_cfg_data[7:0];
                        end
                    end
                    rec_pkg::CFG_START_POS: begin
                        r_cfg_start <= i_cfg_data;
                        if (!r_started) begin
                            r_pos <= i_cfg_data;
                        end
                    end
                    rec_pkg::CFG_PRECISION: begin
                        r_cfg_prec <= i_cfg_data[4:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.shift) begin
                r_range <= {r_range[23:0], 8'h00};
                r_low   <= {r_low[22:0], 8'h00};
                r_pos   <= r_pos + 32'd1;
                if (i_cmd.pend_inc) begin
                    r_pend <= w_pend_inc;
                end else begin
                    r_held <= r_low[30:23];
                end
            end
            if (i_cmd.pend_clr) begin
                r_pend <= 32'd0;
            end
            if (i_cmd.enc_upd) begin
                r_low     <= r_low + r_prod;
                r_range   <= w_use_sub ? (r_range - r_prod) : w_prod;
                r_started <= 1'b1;
            end
            if (i_cmd.pos_add) begin
                r_pos <= r_pos + rec_pkg::C_TRAILER;
            end
            if (i_cmd.restore) begin
                r_low     <= 32'd0;
                r_range   <= rec_pkg::C_RANGE_START;
                r_held    <= r_cfg_first;
                r_pend    <= 32'd0;
                r_pos     <= r_cfg_start;
                r_started <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_stg_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_stg_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_freq <= i_sym_freq;
            r_cum  <= i_cum_freq;
        end
        if (i_cmd.mul_cum) begin
            r_prod <= w_prod;
        end
        if (i_cmd.rnd_calc) begin
            r_rnd <= w_rnd_next;
        end
        if (i_cmd.emit) begin
            r_stg_byte  <= w_em_byte;
            r_stg_count <= w_em_count;
        end
        if (w_push) begin
            r_out_byte  <= r_stg_byte;
            r_out_count <= r_stg_count;
            r_out_last  <= i_cmd.flush;
        end
    end

    assign o_sts.cmd_fin   = (r_cmd == rec_pkg::CMD_FINISH);
    assign o_sts.range_low = (r_range <= rec_pkg::C_RANGE_FLOOR);
    assign o_sts.lo_zone   = (r_low >= rec_pkg::C_LOW_ZONE);
    assign o_sts.lo_top    = r_low[31];
    assign o_sts.pend_nz   = (r_pend != 32'd0);
    assign o_sts.emit_ok   = !r_stg_valid || w_out_free;
    assign o_sts.flush_ok  = w_out_free;
    assign o_sts.stg_valid = r_stg_valid;

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_repeat_count = r_out_count;
    assign o_last         = r_out_last;

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_stg_valid || w_out_free))
        else $error("Result staged while the output register was blocked.");

    a_flush_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_stg_valid && w_out_free))
        else $error("Final result pushed without a staged result or room.");

    a_idle_nothing_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.idle |-> !r_stg_valid)
        else $error("A staged result was left behind at the end of a transaction.");

endmodule

### rtl/rec_ctrl.sv
// ----------------------------------------------------------------------------
// rec_ctrl
// Controller: sequences renormalization, the encode step, the finish flush
// and the handoff of results to the datapath.
// ----------------------------------------------------------------------------
module rec_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  rec_pkg::t_dp_sts i_sts,
    output rec_pkg::t_dp_cmd o_cmd
);

    rec_pkg::t_state r_state;
    rec_pkg::t_state n_state;
    logic [1:0]      r_k;
    logic            w_ren_done;

    assign w_ren_done = (r_k == rec_pkg::C_MAX_SHIFTS) || !i_sts.range_low;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rec_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rec_pkg::ST_REN_TEST;
                end
            end
            rec_pkg::ST_REN_TEST: begin
                if (w_ren_done) begin
                    n_state = i_sts.cmd_fin ? rec_pkg::ST_FIN_POS : rec_pkg::ST_ENC_MUL;
                end else if (!(i_sts.lo_zone && !i_sts.lo_top)) begin
                    n_state = rec_pkg::ST_REN_HELD;
                end
            end
            rec_pkg::ST_REN_HELD: begin
                if (i_sts.emit_ok) begin
                    n_state = i_sts.pend_nz ? rec_pkg::ST_REN_RUN : rec_pkg::ST_REN_TEST;
                end
            end
            rec_pkg::ST_REN_RUN: begin
                if (i_sts.emit_ok) begin
                    n_state = rec_pkg::ST_REN_TEST;
                end
            end
            rec_pkg::ST_ENC_MUL: n_state = rec_pkg::ST_ENC_UPD;
            rec_pkg::ST_ENC_UPD: n_state = rec_pkg::ST_DONE;
            rec_pkg::ST_FIN_POS: n_state = rec_pkg::ST_FIN_RND;
            rec_pkg::ST_FIN_RND: n_state = rec_pkg::ST_FIN_HELD;
            rec_pkg::ST_FIN_HELD: begin
                if (i_sts.emit_ok) begin
                    n_state = i_sts.pend_nz ? rec_pkg::ST_FIN_RUN : rec_pkg::ST_FIN_B0;
                end
            end
            rec_pkg::ST_FIN_RUN: begin
                if (i_sts.emit_ok) begin
                    n_state = rec_pkg::ST_FIN_B0;
                end
            end
            rec_pkg::ST_FIN_B0: begin
                if (i_sts.emit_ok) begin
                    n_state = rec_pkg::ST_FIN_B1;
                end
            end
            rec_pkg::ST_FIN_B1: begin
                if (i_sts.emit_ok) begin
                    n_state = rec_pkg::ST_FIN_B2;
                end
            end
            rec_pkg::ST_FIN_B2: begin
                if (i_sts.emit_ok) begin
                    n_state = rec_pkg::ST_FIN_B3;
                end
            end
            rec_pkg::ST_FIN_B3: begin
                if (i_sts.emit_ok) begin
                    n_state = rec_pkg::ST_DONE;
                end
            end
            rec_pkg::ST_DONE: begin
                if (!i_sts.stg_valid || i_sts.flush_ok) begin
                    n_state = rec_pkg::ST_IDLE;
                end
            end
            default: n_state = rec_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.emit_sel = rec_pkg::EM_HELD;
        unique case (r_state)
            rec_pkg::ST_IDLE: begin
                o_cmd.idle = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rec_pkg::ST_REN_TEST: begin
                if (!w_ren_done && i_sts.lo_zone && !i_sts.lo_top) begin
                    o_cmd.shift    = 1'b1;
                    o_cmd.pend_inc = 1'b1;
                end
            end
            rec_pkg::ST_REN_HELD: begin
                o_cmd.emit  = i_sts.emit_ok;
                o_cmd.shift = i_sts.emit_ok && !i_sts.pend_nz;
            end
            rec_pkg::ST_REN_RUN: begin
                o_cmd.emit_sel = rec_pkg::EM_RUN;
                o_cmd.emit     = i_sts.emit_ok;
                o_cmd.shift    = i_sts.emit_ok;
                o_cmd.pend_clr = i_sts.emit_ok;
            end
            rec_pkg::ST_ENC_MUL: o_cmd.mul_cum = 1'b1;
            rec_pkg::ST_ENC_UPD: o_cmd.enc_upd = 1'b1;
            rec_pkg::ST_FIN_POS: o_cmd.pos_add = 1'b1;
            rec_pkg::ST_FIN_RND: o_cmd.rnd_calc = 1'b1;
            rec_pkg::ST_FIN_HELD: begin
                o_cmd.fin  = 1'b1;
                o_cmd.emit = i_sts.emit_ok;
            end
            rec_pkg::ST_FIN_RUN: begin
                o_cmd.fin      = 1'b1;
                o_cmd.emit_sel = rec_pkg::EM_RUN;
                o_cmd.emit     = i_sts.emit_ok;
                o_cmd.pend_clr = i_sts.emit_ok;
            end
            rec_pkg::ST_FIN_B0: begin
                o_cmd.fin      = 1'b1;
                o_cmd.emit_sel = rec_pkg::EM_RND;
                o_cmd.emit     = i_sts.emit_ok;
            end
            rec_pkg::ST_FIN_B1: begin
                o_cmd.fin      = 1'b1;
                o_cmd.emit_sel = rec_pkg::EM_POS2;
                o_cmd.emit     = i_sts.emit_ok;
            end
            rec_pkg::ST_FIN_B2: begin
                o_cmd.fin      = 1'b1;
                o_cmd.emit_sel = rec_pkg::EM_POS1;
                o_cmd.emit     = i_sts.emit_ok;
            end
            rec_pkg::ST_FIN_B3: begin
                o_cmd.fin      = 1'b1;
                o_cmd.emit_sel = rec_pkg::EM_POS0;
                o_cmd.emit     = i_sts.emit_ok;
                o_cmd.restore  = i_sts.emit_ok;
            end
            rec_pkg::ST_DONE: begin
                o_cmd.flush = i_sts.stg_valid && i_sts.flush_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rec_pkg::ST_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_k <= 2'd0;
            end else if (o_cmd.shift) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    a_shift_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift |-> (r_k != rec_pkg::C_MAX_SHIFTS))
        else $error("More byte shifts than allowed for one transaction.");

endmodule

### rtl/range_encoder_with_carry.sv
// ----------------------------------------------------------------------------
// range_encoder_with_carry
// Range encoder with a 32-bit range register and carry propagation.
//
//   Channel  Direction  Handshake               Payload
//   input    in         i_in_valid/o_in_stall   i_command, i_sym_freq, i_cum_freq
//   output   out        o_out_valid/i_out_stall o_out_byte, o_repeat_count, o_last
//   config   in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction is worked on at a time. An encode transaction without
// renormalization steps through the test, multiply, update and done states.
// Each renormalization shift adds a test pass, plus the held-byte state when
// it sends the held byte and the run state when a pending run follows. A
// finish steps through position, rounding, held byte, any run, trailer, done.
// Output stalls hold the sequencer only when both result registers are full.
// Reset is synchronous and returns the coder to its start state.
// ----------------------------------------------------------------------------
module range_encoder_with_carry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [16:0] i_sym_freq,
    input  logic [15:0] i_cum_freq,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_repeat_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rec_pkg::t_dp_cmd w_cmd;
    rec_pkg::t_dp_sts w_sts;

    rec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rec_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_command      (i_command),
        .i_sym_freq     (i_sym_freq),
        .i_cum_freq     (i_cum_freq),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_repeat_count (o_repeat_count),
        .o_last         (o_last)
    );

    assign o_in_stall  = !w_cmd.idle;
    assign o_cfg_ready = w_cmd.idle;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for range_encoder_with_carry. A scoreboard class keeps
// its own copy of the coder state and registers. For every accepted symbol or
// finish transaction it builds the expected output bytes, and it compares each
// accepted result with the oldest expected one. A short directed sequence
// covers the field extremes and the corner cases: carries, pending runs, zero
// range, finish without symbols, register writes while a stream is open and
// writes to an unused index. Random phases under several register settings
// follow, with random idle cycles on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_BAD_IDX  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_PAUSE  = 40;
    localparam int         BURST_CYCLES = 300;
    localparam int         PHASE_ITEMS  = 26;

    typedef struct packed {
        logic [7:0]  code;
        logic [31:0] count;
        logic        tail;
    } t_coded_out;

    class t_coder_scoreboard;
        logic [7:0]  first_byte_reg;
        logic [31:0] start_pos_reg;
        logic [4:0]  prec_reg;
        logic [31:0] low_q;
        logic [31:0] range_q;
        logic [31:0] pend_q;
        logic [31:0] pos_q;
        logic [7:0]  held_q;
        bit          started;
        t_coded_out  expected_q[$];
        t_coded_out  item_q[$];
        int          failures;
        int          symbols;
        int          finishes;
        int          checked;

        function new();
            first_byte_reg = 8'h00;
            start_pos_reg  = 32'h0;
            prec_reg       = rec_pkg::C_PREC_RESET;
            failures       = 0;
            symbols        = 0;
            finishes       = 0;
            checked        = 0;
            restart();
        endfunction

        function void restart();
            low_q   = 32'h0;
            range_q = rec_pkg::C_RANGE_START;
            held_q  = first_byte_reg;
            pend_q  = 32'h0;
            pos_q   = start_pos_reg;
            started = 1'b0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                rec_pkg::CFG_FIRST_BYTE: begin
                    first_byte_reg = data[7:0];
                    if (!started) held_q = first_byte_reg;
                end
                rec_pkg::CFG_START_POS: begin
                    start_pos_reg = data;
                    if (!started) pos_q = start_pos_reg;
                end
                rec_pkg::CFG_PRECISION: begin
                    prec_reg = data[4:0];
                end
                default: ;
            endcase
        endfunction

        function void push_out(logic [7:0] code, logic [31:0] count);
            t_coded_out r;
            r.code  = code;
            r.count = count;
            r.tail  = 1'b0;
            item_q.push_back(r);
        endfunction

        function void flush_held(logic [7:0] code, logic [7:0] fill);
            push_out(code, 32'd1);
            if (pend_q != 32'h0) push_out(fill, pend_q);
            pend_q = 32'h0;
        endfunction

        function void renormalize();
            logic [31:0] lo;
            for (int k = 0; k < rec_pkg::C_MAX_SHIFTS && range_q <= rec_pkg::C_RANGE_FLOOR;
                 k++) begin
                lo = low_q;
                if (lo >= rec_pkg::C_LOW_ZONE) begin
                    if (lo[31]) begin
                        flush_held(held_q + 8'd1, rec_pkg::C_FILL_ZEROS);
                        held_q = lo[30:23];
                    end else if (pend_q != 32'hFFFF_FFFF) begin
                        pend_q = pend_q + 32'd1;
                    end
                end else begin
                    flush_held(held_q, rec_pkg::C_FILL_ONES);
                    held_q = lo[30:23];
                end
                range_q = range_q << 8;
                low_q   = (lo & rec_pkg::C_LOW_KEEP) << 8;
                pos_q   = pos_q + 32'd1;
            end
        endfunction

        function void note_input(logic cmd, logic [16:0] freq, logic [15:0] cum);
            logic [31:0] step;
            logic [31:0] delta;
            logic [31:0] span;
            logic [31:0] rnd;
            item_q.delete();
            renormalize();
            if (cmd == rec_pkg::CMD_ENCODE) begin
                step  = range_q >> prec_reg;
                delta = {16'h0, cum} * step;
                low_q = low_q + delta;
                span  = {15'h0, freq} + {16'h0, cum};
                if ((span >> prec_reg) != 32'h0) begin
                    range_q = range_q - delta;
                end else begin
                    range_q = {15'h0, freq} * step;
                end
                started = 1'b1;
                symbols++;
            end else begin
                pos_q = pos_q + rec_pkg::C_TRAILER;
                rnd   = low_q >> 23;
                if ((low_q & rec_pkg::C_LOW_KEEP) >= ((pos_q >> 1) & rec_pkg::C_LOW_KEEP)) begin
                    rnd = rnd + 32'd1;
                end
                if (rnd <= 32'hFF) begin
                    flush_held(held_q, rec_pkg::C_FILL_ONES);
                end else begin
                    flush_held(held_q + 8'd1, rec_pkg::C_FILL_ZEROS);
                end
                push_out(rnd[7:0], 32'd1);
                push_out(pos_q[23:16], 32'd1);
                push_out(pos_q[15:8], 32'd1);
                push_out(pos_q[7:0], 32'd1);
                restart();
                finishes++;
            end
            if (item_q.size() > 0) item_q[item_q.size() - 1].tail = 1'b1;
            foreach (item_q[i]) expected_q.push_back(item_q[i]);
        endfunction

        function void check_result(logic [7:0] code, logic [31:0] count, logic tail);
            t_coded_out e;
            checked++;
            if (expected_q.size() == 0) begin
                $error("Unexpected result: out_byte %0h, repeat_count %0d, last %0b",
                       code, count, tail);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (code !== e.code) begin
                $error("out_byte mismatch: expected %0h, actual %0h", e.code, code);
                failures++;
            end
            if (count !== e.count) begin
                $error("repeat_count mismatch: expected %0d, actual %0d", e.count, count);
                failures++;
            end
            if (tail !== e.tail) begin
                $error("last mismatch: expected %0b, actual %0b", e.tail, tail);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic [16:0] i_sym_freq;
    logic [15:0] i_cum_freq;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic [31:0] o_repeat_count;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_coder_scoreboard sb;
    bit                no_idle = 1'b0;
    int                burst_req = 0;
    int                bursts_done = 0;
    int                settings_used = 0;
    int                cycle_count = 0;

    range_encoder_with_carry DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_sym_freq     (i_sym_freq),
        .i_cum_freq     (i_cum_freq),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_repeat_count (o_repeat_count),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_byte, o_repeat_count, o_last);
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (burst_req != bursts_done) begin
                i_out_stall = 1'b1;
                repeat (BURST_CYCLES) @(negedge i_clk);
                bursts_done++;
            end
            i_out_stall = !no_idle && ($urandom_range(0, 99) < 8);
        end
    end

    task automatic send_item(logic cmd, logic [16:0] freq, logic [15:0] cum);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < 8) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_command  = cmd;
        i_sym_freq = freq;
        i_cum_freq = cum;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(cmd, freq, cum);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [7:0] first, logic [31:0] start, logic [4:0] prec);
        write_reg(rec_pkg::CFG_FIRST_BYTE, {24'h0, first});
        write_reg(rec_pkg::CFG_START_POS, start);
        write_reg(rec_pkg::CFG_PRECISION, {27'h0, prec});
        settings_used++;
    endtask

    task automatic random_symbol();
        logic [16:0] total;
        logic [15:0] cum;
        logic [16:0] freq;
        int          pick;
        total = 17'd1 << sb.prec_reg;
        pick  = $urandom_range(0, 99);
        if (pick < 3) begin
            send_item(rec_pkg::CMD_FINISH, 17'($urandom_range(0, 65536)),
                      16'($urandom_range(0, 65535)));
        end else if (pick < 12) begin
            send_item(rec_pkg::CMD_ENCODE, 17'($urandom_range(0, 65536)),
                      16'($urandom_range(0, 65535)));
        end else begin
            cum  = 16'($urandom_range(0, total - 17'd1));
            freq = 17'($urandom_range(1, total - {1'b0, cum}));
            send_item(rec_pkg::CMD_ENCODE, freq, cum);
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = rec_pkg::CMD_ENCODE;
        i_sym_freq  = 17'h0;
        i_cum_freq  = 16'h0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rec_pkg::CFG_FIRST_BYTE;
        i_cfg_data  = 32'h0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(rec_pkg::CMD_FINISH, 17'd0, 16'd0);
        drain_results();

        configure(8'hFF, 32'hFFFF_FFFF, 5'd16);
        write_reg(CFG_BAD_IDX, $urandom);
        send_item(rec_pkg::CMD_ENCODE, 17'd65536, 16'd0);
        send_item(rec_pkg::CMD_ENCODE, 17'd1, 16'd65535);
        send_item(rec_pkg::CMD_ENCODE, 17'd0, 16'd0);
        send_item(rec_pkg::CMD_ENCODE, 17'd5, 16'd7);
        send_item(rec_pkg::CMD_ENCODE, 17'd65535, 16'd0);
        send_item(rec_pkg::CMD_FINISH, 17'd65536, 16'd65535);
        drain_results();

        configure(8'hFF, 32'h00FF_FFFE, 5'd1);
        send_item(rec_pkg::CMD_ENCODE, 17'd0, 16'd3);
        send_item(rec_pkg::CMD_ENCODE, 17'd0, 16'd0);
        send_item(rec_pkg::CMD_ENCODE, 17'd1, 16'd1);
        send_item(rec_pkg::CMD_ENCODE, 17'd1, 16'd0);
        send_item(rec_pkg::CMD_FINISH, 17'd0, 16'd0);
        send_item(rec_pkg::CMD_ENCODE, 17'd2, 16'd0);
        drain_results();

        // Stream open: first byte and start position apply from the next finish.
        write_reg(rec_pkg::CFG_FIRST_BYTE, 32'h5A);
        write_reg(rec_pkg::CFG_START_POS, 32'h1234_5678);
        write_reg(rec_pkg::CFG_PRECISION, 32'd8);
        send_item(rec_pkg::CMD_ENCODE, 17'd100, 16'd50);
        send_item(rec_pkg::CMD_FINISH, 17'd0, 16'd0);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       configure(8'h00, 32'h0, rec_pkg::C_PREC_RESET);
                1:       configure(8'($urandom), 32'hFFFF_FFFF - $urandom_range(0, 20), 5'd16);
                2:       configure(8'hFF, $urandom, 5'd1);
                default: configure(8'($urandom), $urandom, 5'($urandom_range(1, 16)));
            endcase
            no_idle = (ph == 0);
            if (ph == 1) burst_req++;
            for (int n = 0; n < PHASE_ITEMS; n++) random_symbol();
            send_item(rec_pkg::CMD_FINISH, 17'($urandom_range(0, 65536)),
                      16'($urandom_range(0, 65535)));
            drain_results();
        end
        no_idle = 1'b0;

        $display("Run covered %0d symbols and %0d stream finishes over %0d register settings,",
                 sb.symbols, sb.finishes, settings_used);
        $display("with %0d results compared and %0d output hold-off bursts.",
                 sb.checked, bursts_done);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rec_pkg.sv
rtl/rec_dp.sv
rtl/rec_ctrl.sv
rtl/range_encoder_with_carry.sv
sim/testbench.sv
